[sv/jse_pkg.sv]
package jse_pkg;

    // Input item: one source byte or the end-of-string marker.
    typedef struct packed {
        logic       has_byte;
        logic [7:0] in_byte;
    } t_in_item;

    // Result item: one escaped character or the end-of-string status.
    typedef struct packed {
        logic [7:0]  out_char;
        logic        is_end;
        logic        overflowed;
        logic [15:0] out_length;
        logic        last;
    } t_out_item;

    // How the back end expands one queued entry.
    typedef enum logic [1:0] {
        K_PLAIN = 2'd0,
        K_SHORT = 2'd1,
        K_UNI   = 2'd2,
        K_END   = 2'd3
    } t_kind;

    // One entry of the queue between the front and the back end.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  ch;
        logic        overflowed;
        logic [15:0] length;
    } t_desc;

    localparam logic [15:0] CAP_RESET = 16'd4096;

    localparam logic [7:0] CH_CTRL_LIMIT = 8'h20;
    localparam logic [7:0] CH_BSLASH     = 8'h5C;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_N          = 8'h6E;
    localparam logic [7:0] CH_R          = 8'h72;
    localparam logic [7:0] CH_T          = 8'h74;
    localparam logic [7:0] CH_U          = 8'h75;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NUL        = 8'h00;

    localparam logic [2:0] LEN_PLAIN = 3'd1;
    localparam logic [2:0] LEN_SHORT = 3'd2;
    localparam logic [2:0] LEN_UNI   = 3'd6;

    // Lower-case hex digit of a nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'h0, v};
        end else begin
            r = 8'h57 + {4'h0, v};
        end
        return r;
    endfunction

endpackage

[sv/jse_front.sv]
module jse_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  jse_pkg::t_in_item   i_item,
    input  logic [15:0]         i_capacity,
    input  logic                i_q_full,
    output logic                o_q_push,
    output jse_pkg::t_desc      o_q_desc
);

    logic [15:0]     r_count;
    logic            r_ovf;
    logic [15:0]     n_count;
    logic            n_ovf;
    logic            accept;
    jse_pkg::t_kind  kind;
    logic [7:0]      ch;
    logic [2:0]      len;
    logic [16:0]     sum;
    logic            fits;

    assign accept = i_push && !i_q_full;

    // Classify the byte and find the length of its escape.
    always_comb begin
        kind = jse_pkg::K_PLAIN;
        ch   = i_item.in_byte;
        len  = jse_pkg::LEN_PLAIN;
        unique case (i_item.in_byte)
            jse_pkg::CH_BSLASH: begin
                kind = jse_pkg::K_SHORT;
                ch   = jse_pkg::CH_BSLASH;
                len  = jse_pkg::LEN_SHORT;
            end
            jse_pkg::CH_DQUOTE: begin
                kind = jse_pkg::K_SHORT;
                ch   = jse_pkg::CH_DQUOTE;
                len  = jse_pkg::LEN_SHORT;
            end
            jse_pkg::CH_LF: begin
                kind = jse_pkg::K_SHORT;
                ch   = jse_pkg::CH_N;
                len  = jse_pkg::LEN_SHORT;
            end
            jse_pkg::CH_CR: begin
                kind = jse_pkg::K_SHORT;
                ch   = jse_pkg::CH_R;
                len  = jse_pkg::LEN_SHORT;
            end
            jse_pkg::CH_TAB: begin
                kind = jse_pkg::K_SHORT;
                ch   = jse_pkg::CH_T;
                len  = jse_pkg::LEN_SHORT;
            end
            default: begin
                if (i_item.in_byte < jse_pkg::CH_CTRL_LIMIT) begin
                    kind = jse_pkg::K_UNI;
                    len  = jse_pkg::LEN_UNI;
                end
            end
        endcase
    end

    // The whole escape must fit and still leave room for the terminator.
    assign sum  = {1'b0, r_count} + {14'd0, len};
    assign fits = sum < {1'b0, i_capacity};

    always_comb begin
        n_count  = r_count;
        n_ovf    = r_ovf;
        o_q_push = 1'b0;
        o_q_desc = '{kind: kind, ch: ch, overflowed: 1'b0, length: 16'd0};
        if (accept) begin
            if (!i_item.has_byte) begin
                o_q_push = 1'b1;
                o_q_desc = '{kind: jse_pkg::K_END, ch: jse_pkg::CH_NUL,
                             overflowed: r_ovf || (r_count >= i_capacity),
                             length: r_count};
                n_count  = 16'd0;
                n_ovf    = 1'b0;
            end else if (!r_ovf) begin
                if (fits) begin
                    o_q_push = 1'b1;
                    n_count  = sum[15:0];
                end else begin
                    n_ovf = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 16'd0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_item.has_byte |=> r_count == 16'd0 && !r_ovf)
        else $error("count not cleared after end of string");

endmodule

[sv/jse_queue.sv]
module jse_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jse_pkg::t_desc  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output jse_pkg::t_desc  o_data,
    output logic            o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    jse_pkg::t_desc     r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_cnt;

    assign o_full  = r_cnt == CNT_W'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop) && !(i_pop && o_empty))
        else $error("queue written when full or read when empty");

endmodule

[sv/jse_back.sv]
module jse_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  jse_pkg::t_desc      i_q_data,
    input  logic                i_q_empty,
    output logic                o_q_pop,
    output logic                o_empty,
    input  logic                i_pop,
    output jse_pkg::t_out_item  o_item
);

    jse_pkg::t_desc      r_cur;
    logic                r_cur_vld;
    logic [2:0]          r_idx;
    jse_pkg::t_out_item  r_out;
    logic                r_out_vld;
    logic [7:0]          cur_char;
    logic                cur_last;
    logic                out_load;
    logic                adv_last;
    logic                take;

    // Character at the current position of the escape.
    always_comb begin
        cur_char = r_cur.ch;
        cur_last = 1'b1;
        case (r_cur.kind)
            jse_pkg::K_PLAIN: begin
                cur_char = r_cur.ch;
            end
            jse_pkg::K_SHORT: begin
                cur_char = (r_idx == 3'd0) ? jse_pkg::CH_BSLASH : r_cur.ch;
                cur_last = r_idx == jse_pkg::LEN_SHORT - 3'd1;
            end
            jse_pkg::K_UNI: begin
                case (r_idx)
                    3'd0:    cur_char = jse_pkg::CH_BSLASH;
                    3'd1:    cur_char = jse_pkg::CH_U;
                    3'd2:    cur_char = jse_pkg::CH_ZERO;
                    3'd3:    cur_char = jse_pkg::CH_ZERO;
                    3'd4:    cur_char = jse_pkg::hex_digit(r_cur.ch[7:4]);
                    default: cur_char = jse_pkg::hex_digit(r_cur.ch[3:0]);
                endcase
                cur_last = r_idx == jse_pkg::LEN_UNI - 3'd1;
            end
            default: begin
                cur_char = jse_pkg::CH_NUL;
            end
        endcase
    end

    assign out_load = r_cur_vld && (!r_out_vld || i_pop);
    assign adv_last = out_load && cur_last;
    assign take     = (!r_cur_vld || adv_last) && !i_q_empty;
    assign o_q_pop  = take;
    assign o_empty  = !r_out_vld;
    assign o_item   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_vld <= 1'b0;
            r_idx     <= 3'd0;
            r_out_vld <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
            if (take) begin
                r_cur_vld <= 1'b1;
                r_idx     <= 3'd0;
            end else if (adv_last) begin
                r_cur_vld <= 1'b0;
            end else if (out_load) begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cur <= i_q_data;
        end
        if (out_load) begin
            r_out.out_char   <= cur_char;
            r_out.is_end     <= r_cur.kind == jse_pkg::K_END;
            r_out.overflowed <= (r_cur.kind == jse_pkg::K_END) && r_cur.overflowed;
            r_out.out_length <= (r_cur.kind == jse_pkg::K_END) ? r_cur.length : 16'd0;
            r_out.last       <= cur_last;
        end
    end

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_item.is_end |-> o_item.last && o_item.out_char == jse_pkg::CH_NUL)
        else $error("end result without last or terminator");

    a_char_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !o_item.is_end |->
            o_item.out_char != jse_pkg::CH_NUL && !o_item.overflowed
            && o_item.out_length == 16'd0)
        else $error("character result carries status fields");

endmodule

[sv/json_string_escape_encoder_top.sv]
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+---------------------------------
// input     | in        | i_push / o_full           | i_in_item (has_byte, in_byte)
// result    | out       | o_empty / i_pop           | o_out_item (out_char .. last)
// config    | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (output_capacity)
//
// The input side takes one item per clock while the queue has room.
// The back end sends one character per clock while results are popped: a byte
// escape expands to 1, 2 or 6 characters, and the end item to one; the queue of
// QUEUE_DEPTH entries lets short runs of escapes pass without stalling the input.
// The first result of an item passes through the queue, the back end's current
// entry register and the result register before it reaches the result ports.
// Reset is synchronous and active low; it empties the queue and the result
// register, clears the count and sets the capacity to 4096.
module json_string_escape_encoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  jse_pkg::t_in_item   i_in_item,
    output logic                o_empty,
    input  logic                i_pop,
    output jse_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data
);

    // Capacity register, always ready: the user must write it only while the block
    // is idle, which the block does not enforce, so the front sees a settled value.
    logic [15:0] r_capacity;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= jse_pkg::CAP_RESET;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    // The front classifies each byte, checks the escape against the capacity,
    // keeps the running count and overflow state, and queues one entry for
    // every item that produces results.
    logic            q_push;
    logic            q_full;
    jse_pkg::t_desc  q_wdata;
    logic            q_pop;
    logic            q_empty;
    jse_pkg::t_desc  q_rdata;

    assign o_full = q_full;

    jse_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_item     (i_in_item),
        .i_capacity (r_capacity),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_desc   (q_wdata)
    );

    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // The back end walks each entry one character at a time into an output
    // register, so a new character loads in the same cycle the old one pops.
    jse_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_data  (q_rdata),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_empty   (o_empty),
        .i_pop     (i_pop && !o_empty),
        .o_item    (o_out_item)
    );

endmodule
